### rtl/spr_pkg.sv
// Shared widths, reset values, register indexes and types for the setpoint ramp.
package spr_pkg;

  localparam int SPEED_W    = 12;
  localparam int DIST_W     = 20;
  localparam int STEP_W     = 8;
  localparam int BSTEP_W    = 10;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 20;

  localparam int DEBOUNCE_TICKS_DEF = 3;

  localparam logic [SPEED_W-1:0] CRUISE_RESET = SPEED_W'(1700);

  localparam logic [CFG_IDX_W-1:0] REG_ACCEL_STEP   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_DECEL_STEP   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_BUTTON_STEP  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_MIN_CRUISE   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_CRUISE   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_APPROACH     = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_SLOW_DIST    = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_ARM_DIST     = 3'd7;

  typedef struct packed {
    logic [STEP_W-1:0]  accel_step;
    logic [STEP_W-1:0]  decel_step;
    logic [BSTEP_W-1:0] button_step;
    logic [SPEED_W-1:0] min_cruise;
    logic [SPEED_W-1:0] max_cruise;
    logic [SPEED_W-1:0] approach_speed;
    logic [DIST_W-1:0]  slow_distance_mm;
    logic [DIST_W-1:0]  arm_distance_mm;
  } cfg_t;

  localparam cfg_t CFG_RESET = '{
    accel_step:       STEP_W'(8),
    decel_step:       STEP_W'(5),
    button_step:      BSTEP_W'(40),
    min_cruise:       SPEED_W'(1700),
    max_cruise:       SPEED_W'(2400),
    approach_speed:   SPEED_W'(1640),
    slow_distance_mm: DIST_W'(5000),
    arm_distance_mm:  DIST_W'(5000)
  };

  typedef struct packed {
    logic up_press;
    logic down_press;
  } press_t;

endpackage

### rtl/spr_debounce.sv
// Stable-count debounce filter for one active-low button, with press-edge detect.
module spr_debounce #(
  parameter int DEBOUNCE_TICKS = spr_pkg::DEBOUNCE_TICKS_DEF
) (
  input  logic clk,
  input  logic rst,
  input  logic advance,
  input  logic sample,
  output logic press
);
  import spr_pkg::*;

  localparam int CNT_W = $clog2(DEBOUNCE_TICKS + 1);
  localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(DEBOUNCE_TICKS);

  logic             last;
  logic             stable;
  logic [CNT_W-1:0] count;
  logic             last_next;
  logic             stable_next;
  logic [CNT_W-1:0] count_next;
  logic             flip;

  always_comb begin
    last_next = last;
    if (sample == last) begin
      count_next = (count < CNT_MAX) ? count + CNT_W'(1) : count;
    end else begin
      last_next  = sample;
      count_next = '0;
    end
    flip        = (count_next >= CNT_MAX) && (sample != stable);
    stable_next = flip ? sample : stable;
    press       = flip && !sample;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      last   <= 1'b1;
      stable <= 1'b1;
      count  <= '0;
    end else if (advance) begin
      last   <= last_next;
      stable <= stable_next;
      count  <= count_next;
    end
  end

endmodule

### rtl/spr_ramp.sv
// Cruise level adjustment and slew-limited setpoint ramp with its state registers.
module spr_ramp (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         advance,
  input  spr_pkg::press_t              press,
  input  logic [spr_pkg::DIST_W-1:0]   travel_mm,
  input  logic                         run_enable,
  input  logic                         clear_target,
  input  spr_pkg::cfg_t                cfg,
  output logic [spr_pkg::SPEED_W-1:0]  setpoint_next,
  output logic [spr_pkg::SPEED_W-1:0]  cruise_next,
  output logic                         armed
);
  import spr_pkg::*;

  logic [SPEED_W-1:0]        cruise_level;
  logic [SPEED_W-1:0]        setpoint;
  logic [SPEED_W-1:0]        cruise_up;
  logic [SPEED_W:0]          up_sum;
  logic signed [SPEED_W:0]   dn_diff;
  logic [SPEED_W-1:0]        desired;
  logic [SPEED_W:0]          acc_sum;
  logic signed [SPEED_W:0]   dec_diff;
  logic [SPEED_W-1:0]        ramped;

  always_comb begin
    up_sum    = {1'b0, cruise_level} + (SPEED_W+1)'(cfg.button_step);
    cruise_up = cruise_level;
    if (press.up_press) begin
      cruise_up = (up_sum > {1'b0, cfg.max_cruise}) ? cfg.max_cruise : up_sum[SPEED_W-1:0];
    end
    dn_diff     = $signed({1'b0, cruise_up}) - $signed((SPEED_W+1)'(cfg.button_step));
    cruise_next = cruise_up;
    if (press.down_press) begin
      cruise_next = (dn_diff < $signed({1'b0, cfg.min_cruise})) ?
                    cfg.min_cruise : dn_diff[SPEED_W-1:0];
    end
  end

  assign armed = travel_mm >= cfg.arm_distance_mm;

  always_comb begin
    desired = cruise_next;
    if ((travel_mm >= cfg.slow_distance_mm) && (cruise_next > cfg.approach_speed)) begin
      desired = cfg.approach_speed;
    end
    acc_sum  = {1'b0, setpoint} + (SPEED_W+1)'(cfg.accel_step);
    dec_diff = $signed({1'b0, setpoint}) - $signed((SPEED_W+1)'(cfg.decel_step));
    priority if (setpoint < desired) begin
      ramped = (acc_sum > {1'b0, desired}) ? desired : acc_sum[SPEED_W-1:0];
    end else if (setpoint > desired) begin
      ramped = (dec_diff < $signed({1'b0, desired})) ? desired : dec_diff[SPEED_W-1:0];
    end else begin
      ramped = setpoint;
    end
    setpoint_next = setpoint;
    if (run_enable) begin
      setpoint_next = ramped;
    end
    if (clear_target) begin
      setpoint_next = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cruise_level <= CRUISE_RESET;
      setpoint     <= '0;
    end else if (advance) begin
      cruise_level <= cruise_next;
      setpoint     <= setpoint_next;
    end
  end

endmodule

### rtl/speed_setpoint_ramp_with_buttons_unit.sv
// Top level of the speed setpoint ramp: config registers, input and result registers.
//
// Usage:
//   Input channel (in_valid/in_ready) carries one control tick per beat: raw
//   active-low button levels, travelled distance, run and clear flags.
//   Output channel (out_valid/out_ready) returns one result beat per tick:
//   ramped setpoint, cruise level, stop-armed flag and debounced press edges.
//   Configuration is written through cfg_we/cfg_index/cfg_data, one register
//   per cycle; the user must write it only while the block is idle, which the block itself does not enforce.
// Timing:
//   An accepted tick is held in the input register, processed in one pass of
//   adder/compare logic and lands in the result register once that register is
//   free, which raises out_valid. Throughput is one tick per cycle while
//   out_ready stays high, set by the state update of the ramp and debounce
//   registers.
// Reset (rst, synchronous): configuration returns to its defaults, buttons to
//   released, cruise level to 1700 and setpoint to zero; both channels empty.
// Stall: while out_ready is low the result is held; one further tick waits in
//   the input register, after which in_ready drops.
module speed_setpoint_ramp_with_buttons_unit #(
  parameter int DEBOUNCE_TICKS = spr_pkg::DEBOUNCE_TICKS_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_we,
  input  logic [spr_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [spr_pkg::CFG_DATA_W-1:0]  cfg_data,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic                            up_level,
  input  logic                            down_level,
  input  logic [spr_pkg::DIST_W-1:0]      travel_mm,
  input  logic                            run_enable,
  input  logic                            clear_target,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [spr_pkg::SPEED_W-1:0]     target_speed,
  output logic [spr_pkg::SPEED_W-1:0]     cruise_speed,
  output logic                            stop_armed,
  output logic                            up_pressed,
  output logic                            down_pressed
);
  import spr_pkg::*;

  cfg_t               cfg;
  logic               in_full;
  logic               up_q;
  logic               down_q;
  logic [DIST_W-1:0]  dist_q;
  logic               run_q;
  logic               clear_q;
  logic               advance;
  press_t             press;
  logic [SPEED_W-1:0] setpoint_next;
  logic [SPEED_W-1:0] cruise_next;
  logic               armed;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= CFG_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_ACCEL_STEP:  cfg.accel_step       <= cfg_data[STEP_W-1:0];
        REG_DECEL_STEP:  cfg.decel_step       <= cfg_data[STEP_W-1:0];
        REG_BUTTON_STEP: cfg.button_step      <= cfg_data[BSTEP_W-1:0];
        REG_MIN_CRUISE:  cfg.min_cruise       <= cfg_data[SPEED_W-1:0];
        REG_MAX_CRUISE:  cfg.max_cruise       <= cfg_data[SPEED_W-1:0];
        REG_APPROACH:    cfg.approach_speed   <= cfg_data[SPEED_W-1:0];
        REG_SLOW_DIST:   cfg.slow_distance_mm <= cfg_data[DIST_W-1:0];
        REG_ARM_DIST:    cfg.arm_distance_mm  <= cfg_data[DIST_W-1:0];
        default: ;
      endcase
    end
  end

  assign advance  = in_full && (!out_valid || out_ready);
  assign in_ready = !in_full || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_full <= 1'b0;
    end else if (in_ready) begin
      in_full <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      up_q    <= up_level;
      down_q  <= down_level;
      dist_q  <= travel_mm;
      run_q   <= run_enable;
      clear_q <= clear_target;
    end
  end

  spr_debounce #(.DEBOUNCE_TICKS(DEBOUNCE_TICKS)) u_up_deb (
    .clk     (clk),
    .rst     (rst),
    .advance (advance),
    .sample  (up_q),
    .press   (press.up_press)
  );

  spr_debounce #(.DEBOUNCE_TICKS(DEBOUNCE_TICKS)) u_down_deb (
    .clk     (clk),
    .rst     (rst),
    .advance (advance),
    .sample  (down_q),
    .press   (press.down_press)
  );

  spr_ramp u_ramp (
    .clk           (clk),
    .rst           (rst),
    .advance       (advance),
    .press         (press),
    .travel_mm     (dist_q),
    .run_enable    (run_q),
    .clear_target  (clear_q),
    .cfg           (cfg),
    .setpoint_next (setpoint_next),
    .cruise_next   (cruise_next),
    .armed         (armed)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      target_speed <= setpoint_next;
      cruise_speed <= cruise_next;
      stop_armed   <= armed;
      up_pressed   <= press.up_press;
      down_pressed <= press.down_press;
    end
  end

endmodule
